[rtl/htb_pkg.sv]
// ----------------------------------------------------------------------------
// htb_pkg: shared types and constants of the Huffman tree builder
// Item opcodes, result status codes, the sequencer state and the entry and
// control types that travel along the sorted cell chain.
// ----------------------------------------------------------------------------
package htb_pkg;

  localparam int SYMBOLS        = 256;
  localparam int LIST_DEPTH     = 256;
  localparam int SYM_W          = 8;
  localparam int COUNT_W        = 32;
  localparam int NODE_W         = 9;
  localparam int WEIGHT_W       = 40;
  localparam int LEN_W          = $clog2(LIST_DEPTH + 1);
  localparam int FIRST_INTERNAL = 256;
  localparam int LAST_INTERNAL  = 511;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_MERGED = 2'd0,
    ST_DONE   = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_CMP,
    S_INSERT
  } state_e;

  // One list entry held by a cell
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   node;
  } entry_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic cmp;  // capture the compare result against the key
    logic ins;  // insert the key at the first hit, shift the rest right
    logic pop;  // shift the chain left by two entries
    logic ge;   // merge ordering: weight greater or equal wins, no id tiebreak
  } cell_ctrl_t;

endpackage

[rtl/htb_if.sv]
// ----------------------------------------------------------------------------
// htb_if: valid/ready channels of the Huffman tree builder
// htb_in_if carries command items, htb_out_if carries merge results.
// ----------------------------------------------------------------------------
interface htb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  symbol;
  logic [31:0] count;

  modport source (output valid, output op, output symbol, output count, input ready);
  modport sink   (input valid, input op, input symbol, input count, output ready);
endinterface

interface htb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [8:0]  left_node;
  logic [8:0]  right_node;
  logic [8:0]  parent_node;
  logic [39:0] weight;
  logic        final_merge;

  modport source (output valid, output status, output left_node, output right_node,
                  output parent_node, output weight, output final_merge, input ready);
  modport sink   (input valid, input status, input left_node, input right_node,
                  input parent_node, input weight, input final_merge, output ready);
endinterface

[rtl/htb_cell.sv]
// ----------------------------------------------------------------------------
// htb_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast key, and takes part in
// the insert (shift right from the first hit on) and pop (shift left by two).
// ----------------------------------------------------------------------------
module htb_cell (
  input  logic                         clk_i,
  input  htb_pkg::cell_ctrl_t          ctrl_i,
  input  logic [htb_pkg::WEIGHT_W-1:0] key_weight_i,
  input  logic [htb_pkg::NODE_W-1:0]   key_node_i,
  input  htb_pkg::entry_t              ins_entry_i,
  input  logic                         occupied_i,
  input  htb_pkg::entry_t              left_entry_i,
  input  htb_pkg::entry_t              right2_entry_i,
  input  logic                         seen_i,
  output logic                         seen_o,
  output htb_pkg::entry_t              entry_o
);
  import htb_pkg::*;

  entry_t entry_q, entry_d;
  logic   hit_q, hit_d;
  logic   before_me;

  // The key goes ahead of this entry; an empty slot always accepts it
  always_comb begin
    before_me = (entry_q.weight > key_weight_i) ||
                ((entry_q.weight == key_weight_i) &&
                 (ctrl_i.ge || (entry_q.node > key_node_i)));
    hit_d = ctrl_i.cmp ? (!occupied_i || before_me) : hit_q;
  end

  // Pass the "insert point already found" flag down the chain
  assign seen_o = seen_i | hit_q;

  // Shift right behind the insert point, take the key at it, pop by two
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (seen_i) begin
        entry_d = left_entry_i;
      end else if (hit_q) begin
        entry_d = ins_entry_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right2_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/htb_ctrl.sv]
// ----------------------------------------------------------------------------
// htb_ctrl: sequencer of the Huffman tree builder
// Decodes items, keeps list length and the next internal id, drives the cell
// chain and forms merge results in the output register.
// ----------------------------------------------------------------------------
module htb_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  htb_in_if.sink                       in_i,
  htb_out_if.source                    res_o,
  input  htb_pkg::entry_t              head0_i,
  input  htb_pkg::entry_t              head1_i,
  output htb_pkg::cell_ctrl_t          ctrl_o,
  output logic [htb_pkg::WEIGHT_W-1:0] key_weight_o,
  output logic [htb_pkg::NODE_W-1:0]   key_node_o,
  output htb_pkg::entry_t              ins_entry_o,
  output logic [htb_pkg::LEN_W-1:0]    len_o
);
  import htb_pkg::*;

  state_e              state_q, state_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [NODE_W-1:0]   next_id_q, next_id_d;
  entry_t              key_q, key_d;
  logic                accept;
  logic                load_ok;
  logic                slot_free;
  logic                do_pop;
  logic [WEIGHT_W:0]   sum_full;
  logic [WEIGHT_W-1:0] sum_sat;

  logic                out_valid_q, out_valid_d;
  logic [1:0]          status_q, status_d;
  logic [NODE_W-1:0]   left_q, left_d, right_q, right_d, parent_q, parent_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic                final_q, final_d;

  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || res_o.ready;
  assign load_ok   = (in_i.count != '0) && ({1'b0, in_i.symbol} < NODE_W'(SYMBOLS)) &&
                     (len_q != LEN_W'(LIST_DEPTH));
  assign do_pop    = (state_q == S_POP) && slot_free && (len_q >= LEN_W'(2));

  // Saturating sum of the two head weights
  always_comb begin
    sum_full = {1'b0, head0_i.weight} + {1'b0, head1_i.weight};
    sum_sat  = sum_full[WEIGHT_W] ? '1 : sum_full[WEIGHT_W-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.op == OP_LOAD && load_ok) begin
            state_d = S_INSERT;
          end else if (in_i.op == OP_MERGE) begin
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        if (slot_free) begin
          state_d = (len_q >= LEN_W'(2)) ? S_CMP : S_IDLE;
        end
      end
      S_CMP:    state_d = S_INSERT;
      S_INSERT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Cell chain control and handshake
  always_comb begin
    in_i.ready  = (state_q == S_IDLE);
    ctrl_o.cmp  = (state_q == S_IDLE) || (state_q == S_CMP);
    ctrl_o.ins  = (state_q == S_INSERT);
    ctrl_o.pop  = do_pop;
    ctrl_o.ge   = (state_q != S_IDLE);
    if (state_q == S_IDLE) begin
      key_weight_o = WEIGHT_W'(in_i.count);
      key_node_o   = NODE_W'(in_i.symbol);
    end else begin
      key_weight_o = key_q.weight;
      key_node_o   = key_q.node;
    end
  end

  assign ins_entry_o = key_q;
  assign len_o       = len_q;

  // List bookkeeping and the pending key
  always_comb begin
    len_d     = len_q;
    next_id_d = next_id_q;
    key_d     = key_q;
    if (accept) begin
      key_d.weight = WEIGHT_W'(in_i.count);
      key_d.node   = NODE_W'(in_i.symbol);
      unique case (in_i.op)
        OP_CLEAR: begin
          len_d     = '0;
          next_id_d = NODE_W'(FIRST_INTERNAL);
        end
        default: ;
      endcase
    end
    if (do_pop) begin
      key_d.weight = sum_sat;
      key_d.node   = next_id_q;
      len_d        = len_q - LEN_W'(2);
      next_id_d    = (next_id_q == NODE_W'(LAST_INTERNAL)) ? NODE_W'(FIRST_INTERNAL)
                                                          : next_id_q + NODE_W'(1);
    end
    if (state_q == S_INSERT) begin
      len_d = len_q + LEN_W'(1);
    end
  end

  // Output register: fill on a merge, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    left_d      = left_q;
    right_d     = right_q;
    parent_d    = parent_q;
    weight_d    = weight_q;
    final_d     = final_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_POP && slot_free) begin
      out_valid_d = 1'b1;
      left_d      = '0;
      right_d     = '0;
      parent_d    = '0;
      weight_d    = '0;
      final_d     = 1'b0;
      if (len_q == '0) begin
        status_d = ST_EMPTY;
      end else if (len_q == LEN_W'(1)) begin
        status_d = ST_DONE;
        parent_d = head0_i.node;
        weight_d = head0_i.weight;
      end else begin
        status_d = ST_MERGED;
        left_d   = head0_i.node;
        right_d  = head1_i.node;
        parent_d = next_id_q;
        weight_d = sum_sat;
        final_d  = (len_q == LEN_W'(2));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      next_id_q   <= NODE_W'(FIRST_INTERNAL);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    left_q   <= left_d;
    right_q  <= right_d;
    parent_q <= parent_d;
    weight_q <= weight_d;
    final_q  <= final_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.left_node   = left_q;
  assign res_o.right_node  = right_q;
  assign res_o.parent_node = parent_q;
  assign res_o.weight      = weight_q;
  assign res_o.final_merge = final_q;

endmodule

[rtl/huffman_tree_builder.sv]
// ----------------------------------------------------------------------------
// huffman_tree_builder: Huffman tree construction over a sorted cell chain
// Keeps up to 256 nodes in a chain of cells sorted by ascending weight.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items (op, symbol, count). A load inserts a leaf, a merge
//   pops the two lightest nodes and reinserts their sum, a clear empties the
//   list. res_o carries one result per merge item only.
//   Every cell compares its entry with the key in the same cycle; the first
//   hit is found by a flag passed cell to cell, so an insert shifts all cells at once.
//   A load steps through accept with compare, then insert; a clear or an
//   ignored item only through the accept. A merge of two nodes steps through
//   accept, pop-two with the add, compare against the sum and insert; a merge
//   on a list of one node or none steps through accept and pop. The result is
//   registered at the end of the pop step.
//   One item is worked on at a time; in_i.ready is high only while idle.
//   If res_o stalls with a result still held, a following merge waits in its
//   pop cycle until the output register frees; loads and clears go on.
//   Reset empties the list and restarts internal ids at 256; no clearing
//   pass is needed since only entries below the list length are read.
// ----------------------------------------------------------------------------
module huffman_tree_builder (
  input  logic      clk_i,
  input  logic      rst_ni,
  htb_in_if.sink    in_i,
  htb_out_if.source res_o
);
  import htb_pkg::*;

  cell_ctrl_t          ctrl;
  logic [WEIGHT_W-1:0] key_weight;
  logic [NODE_W-1:0]   key_node;
  entry_t              ins_entry;
  logic [LEN_W-1:0]    len;
  entry_t              entries [LIST_DEPTH];
  logic [LIST_DEPTH:0] seen;
  logic [LIST_DEPTH-1:0] occupied;

  htb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .res_o        (res_o),
    .head0_i      (entries[0]),
    .head1_i      (entries[1]),
    .ctrl_o       (ctrl),
    .key_weight_o (key_weight),
    .key_node_o   (key_node),
    .ins_entry_o  (ins_entry),
    .len_o        (len)
  );

  assign seen[0] = 1'b0;

  // Build the chain; the ends see empty neighbors
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    entry_t left_entry;
    entry_t right2_entry;

    assign occupied[g] = (LEN_W'(g) < len);

    if (g == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_mid
      assign left_entry = entries[g-1];
    end

    if (g + 2 < LIST_DEPTH) begin : g_pop
      assign right2_entry = entries[g+2];
    end else begin : g_tail
      assign right2_entry = '0;
    end

    htb_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .key_weight_i   (key_weight),
      .key_node_i     (key_node),
      .ins_entry_i    (ins_entry),
      .occupied_i     (occupied[g]),
      .left_entry_i   (left_entry),
      .right2_entry_i (right2_entry),
      .seen_i         (seen[g]),
      .seen_o         (seen[g+1]),
      .entry_o        (entries[g])
    );
  end

endmodule

[rtl/htb_checker.sv]
// ----------------------------------------------------------------------------
// htb_checker: port-level checks of the Huffman tree builder
// Watches the item and result channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module htb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  res_status_i,
  input logic [8:0]  res_left_i,
  input logic [8:0]  res_right_i,
  input logic        res_final_i
);
  import htb_pkg::*;

  // Hold a result until it is taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before taken");

  // Only merged results name popped children or flag the final merge
  a_res_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != ST_MERGED |->
      res_left_i == '0 && res_right_i == '0 && !res_final_i)
    else $error("non-merge result carries child fields");

  // Never report a code outside the status set
  a_res_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_status_i == ST_MERGED || res_status_i == ST_DONE ||
                    res_status_i == ST_EMPTY)
    else $error("bad result status");

  // A merge keeps the block busy for the next cycle
  a_merge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_MERGE |=> !in_ready_i)
    else $error("merge accepted without busy cycle");

endmodule

bind huffman_tree_builder htb_checker u_htb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .res_left_i   (res_o.left_node),
  .res_right_i  (res_o.right_node),
  .res_final_i  (res_o.final_merge)
);

[tb/huffman_tree_builder_test.sv]
// ----------------------------------------------------------------------------
// huffman_tree_builder_test: self-checking bench for the Huffman tree builder
// Drives load, merge, clear and unused items over the command channel, keeps
// its own sorted node list to predict every merge result, and compares each
// result field by field. It covers directed corner cases, a full list with
// weight saturation and id wrap, a long result stall, and random trees.
// ----------------------------------------------------------------------------
module huffman_tree_builder_test;
  import htb_pkg::*;

  localparam int          CLK_PERIOD   = 8;
  localparam int          RESET_CYCLES = 11;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 870;
  localparam int          TAIL_CYCLES  = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [39:0] WEIGHT_MAX   = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  typedef struct packed {
    status_e             status;
    logic [NODE_W-1:0]   left_node;
    logic [NODE_W-1:0]   right_node;
    logic [NODE_W-1:0]   parent_node;
    logic [WEIGHT_W-1:0] weight;
    logic                final_merge;
  } merge_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  htb_in_if  cmd_if ();
  htb_out_if res_if ();

  huffman_tree_builder uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .res_o  (res_if)
  );

  // Predicted list of nodes, sorted by ascending weight
  logic [WEIGHT_W-1:0] tree_weight [LIST_DEPTH];
  logic [NODE_W-1:0]   tree_node   [LIST_DEPTH];
  int unsigned         tree_len = 0;
  logic [NODE_W-1:0]   next_parent = NODE_W'(FIRST_INTERNAL);

  merge_res_t  pending_merges [$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          idling_on = 1'b0;
  int          rx_hold_left = 0;
  int          rx_stall_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Open a slot at pos and store the node there
  function automatic void place_node(int unsigned pos, logic [WEIGHT_W-1:0] w,
                                     logic [NODE_W-1:0] id);
    for (int unsigned i = tree_len; i > pos; i--) begin
      tree_weight[i] = tree_weight[i - 1];
      tree_node[i]   = tree_node[i - 1];
    end
    tree_weight[pos] = w;
    tree_node[pos]   = id;
    tree_len++;
  endfunction

  // Apply one accepted item to the predicted list; queue a merge result
  function automatic void tree_step(logic [1:0] op, logic [SYM_W-1:0] sym,
                                    logic [COUNT_W-1:0] cnt);
    int unsigned   pos;
    logic [WEIGHT_W:0] sum;
    merge_res_t    res;
    res = '0;
    case (op)
      OP_LOAD: begin
        if (cnt != 0 && int'(sym) < SYMBOLS && tree_len < LIST_DEPTH) begin
          pos = 0;
          while (pos < tree_len &&
                 !(tree_weight[pos] > cnt ||
                   (tree_weight[pos] == cnt && tree_node[pos] > sym)))
            pos++;
          place_node(pos, WEIGHT_W'(cnt), NODE_W'(sym));
        end
      end
      OP_CLEAR: begin
        tree_len    = 0;
        next_parent = NODE_W'(FIRST_INTERNAL);
      end
      OP_MERGE: begin
        if (tree_len == 0) begin
          res.status = ST_EMPTY;
        end else if (tree_len == 1) begin
          res.status      = ST_DONE;
          res.parent_node = tree_node[0];
          res.weight      = tree_weight[0];
        end else begin
          res.status      = ST_MERGED;
          res.left_node   = tree_node[0];
          res.right_node  = tree_node[1];
          res.parent_node = next_parent;
          sum = {1'b0, tree_weight[0]} + {1'b0, tree_weight[1]};
          res.weight = sum[WEIGHT_W] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
          // Drop the two head nodes
          for (int unsigned i = 0; i + 2 < tree_len; i++) begin
            tree_weight[i] = tree_weight[i + 2];
            tree_node[i]   = tree_node[i + 2];
          end
          tree_len -= 2;
          // Insert the parent ahead of the first entry of equal or more weight
          pos = 0;
          while (pos < tree_len && tree_weight[pos] < res.weight) pos++;
          place_node(pos, res.weight, next_parent);
          next_parent = (next_parent == NODE_W'(LAST_INTERNAL)) ?
                        NODE_W'(FIRST_INTERNAL) : next_parent + 1'b1;
          res.final_merge = (tree_len == 1);
        end
        pending_merges.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [WEIGHT_W-1:0] want,
                             logic [WEIGHT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    merge_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_merges.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d parent %0h",
                 $time, res_if.status, res_if.parent_node);
      end else begin
        want = pending_merges.pop_front();
        check_field("status",      want.status,      res_if.status);
        check_field("left_node",   want.left_node,   res_if.left_node);
        check_field("right_node",  want.right_node,  res_if.right_node);
        check_field("parent_node", want.parent_node, res_if.parent_node);
        check_field("weight",      want.weight,      res_if.weight);
        check_field("final_merge", want.final_merge, res_if.final_merge);
      end
    end
  end

  // Result side: long holds on request, short random stalls while idling is on
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      res_if.ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      res_if.ready <= 1'b0;
      rx_stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      rx_stall_left = $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Offer one item from a falling edge and hold it until accepted
  task automatic send_item(logic [1:0] op, logic [SYM_W-1:0] sym,
                           logic [COUNT_W-1:0] cnt);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.op     <= op;
    cmd_if.symbol <= sym;
    cmd_if.count  <= cnt;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    tree_step(op, sym, cnt);
    @(negedge clk);
  endtask

  // Stop offering items until every predicted result has arrived
  task automatic wait_results_drained();
    cmd_if.valid <= 1'b0;
    do @(negedge clk); while (pending_merges.size() != 0);
  endtask

  // Empty list, ignored items and a single root
  task automatic test_empty_and_root();
    idling_on = 1'b1;
    send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_LOAD, 8'd9, 32'd0);
    send_item(OP_UNUSED, 8'hFF, COUNT_MAX);
    send_item(OP_LOAD, 8'd0, 32'd1);
    send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_CLEAR, 8'd0, 32'd0);
    send_item(OP_MERGE, 8'd0, 32'd0);
    wait_results_drained();
  endtask

  // Tie ordering, repeated symbols and loads after merges
  task automatic test_tie_order();
    send_item(OP_LOAD, 8'd200, 32'd5);
    send_item(OP_LOAD, 8'd10, 32'd5);
    send_item(OP_LOAD, 8'd100, 32'd5);
    send_item(OP_LOAD, 8'd10, 32'd5);
    send_item(OP_LOAD, 8'd255, COUNT_MAX);
    send_item(OP_LOAD, 8'd0, 32'd1);
    repeat (6) send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_CLEAR, 8'd0, 32'd0);
    // Sum equal to a leaf goes ahead of it; a leaf equal to a parent goes first
    send_item(OP_LOAD, 8'd3, 32'd2);
    send_item(OP_LOAD, 8'd4, 32'd2);
    send_item(OP_LOAD, 8'd5, 32'd4);
    send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_LOAD, 8'd6, 32'd4);
    repeat (3) send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_CLEAR, 8'd0, 32'd0);
    wait_results_drained();
  endtask

  // Fill all entries, then merge past weight saturation and id wrap
  task automatic test_full_list_saturation();
    idling_on = $urandom_range(0, 1);
    for (int i = 0; i < LIST_DEPTH; i++) send_item(OP_LOAD, SYM_W'(i), COUNT_MAX);
    send_item(OP_LOAD, 8'd5, COUNT_MAX);
    send_item(OP_LOAD, 8'd6, 32'd1);
    repeat (LIST_DEPTH - 1) send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_LOAD, 8'd3, COUNT_MAX);
    send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_LOAD, 8'd4, COUNT_MAX);
    send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_CLEAR, 8'd0, 32'd0);
    wait_results_drained();
  endtask

  // Hold results off while merges keep coming so the input stalls
  task automatic test_result_backpressure();
    idling_on = 1'b0;
    rx_hold_left = 150;
    for (int i = 0; i < 12; i++)
      send_item(OP_LOAD, SYM_W'($urandom), $urandom_range(1, 1000));
    repeat (12) send_item(OP_MERGE, 8'd0, 32'd0);
    send_item(OP_CLEAR, 8'd0, 32'd0);
    wait_results_drained();
  endtask

  // Random trees: loads then merges, with noise, clears and pauses
  task automatic test_random_trees();
    int unsigned        sent;
    int unsigned        leaves;
    int unsigned        style;
    logic [COUNT_W-1:0] w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idling_on = (sent < RANDOM_ITEMS * 7 / 10) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        send_item(OP_CLEAR, SYM_W'($urandom), $urandom);
        sent++;
      end
      leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      style  = $urandom_range(0, 2);
      for (int unsigned i = 0; i < leaves; i++) begin
        case (style)
          0:       w = $urandom_range(1, 6);
          1:       w = $urandom;
          default: w = COUNT_MAX - $urandom_range(0, 15);
        endcase
        if ($urandom_range(0, 15) == 0) w = '0;
        send_item(OP_LOAD, SYM_W'($urandom), w);
        sent++;
      end
      // Extra merges reach the root and the empty list
      for (int unsigned i = 0; i < leaves + $urandom_range(0, 2); i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_LOAD, SYM_W'($urandom), $urandom);
          sent++;
        end
        if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, SYM_W'($urandom), $urandom);
        send_item(OP_MERGE, SYM_W'($urandom), $urandom);
        sent++;
      end
      if ($urandom_range(0, 4) == 0) wait_results_drained();
    end
  endtask

  initial begin
    cmd_if.valid  = 1'b0;
    cmd_if.op     = OP_LOAD;
    cmd_if.symbol = '0;
    cmd_if.count  = '0;
    res_if.ready  = 1'b0;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_root();
    test_tie_order();
    test_full_list_saturation();
    test_result_backpressure();
    test_random_trees();

    idling_on = 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_merges.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
